// ===== rtl/uyvy_crop_to_rgb565_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the UYVY crop and RGB565 conversion block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UYVY_CROP_TO_RGB565_ASSERT_SVH
`define UYVY_CROP_TO_RGB565_ASSERT_SVH

// condition implies consequence in the same cycle
`define UCROP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define UCROP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ucrop_pkg.sv =====
// ---------------------------------------------------------------------------
// ucrop_pkg
// Shared constants and types of the UYVY crop and RGB565 conversion block.
// ---------------------------------------------------------------------------
package ucrop_pkg;

  // native frame geometry
  localparam int NATIVE_WIDTH  = 480;
  localparam int NATIVE_HEIGHT = 480;

  localparam int REG_W      = 9;
  localparam int CFG_ADDR_W = 2;
  localparam int COL_W      = (NATIVE_WIDTH > 2) ? $clog2(NATIVE_WIDTH) : 1;
  localparam int ROW_W      = $clog2(NATIVE_HEIGHT + 1);
  localparam int NATIVE_MAX = (NATIVE_WIDTH > NATIVE_HEIGHT) ? NATIVE_WIDTH : NATIVE_HEIGHT;
  localparam int CMP_W      = $clog2(NATIVE_MAX + 2 * (1 << REG_W) + 2);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CROP_LEFT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CROP_TOP   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_HEIGHT = 2'd3;

  localparam logic [REG_W-1:0] RST_CROP_LEFT  = 9'd80;
  localparam logic [REG_W-1:0] RST_CROP_TOP   = 9'd120;
  localparam logic [REG_W-1:0] RST_OUT_WIDTH  = 9'd320;
  localparam logic [REG_W-1:0] RST_OUT_HEIGHT = 9'd240;

  // group queue, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // BT.601 limited range coefficients
  localparam int PROD_W = 18;
  localparam int SUM_W  = 20;
  localparam logic signed [PROD_W-1:0] K_Y    = 18'sd298;
  localparam logic signed [PROD_W-1:0] K_RV   = 18'sd409;
  localparam logic signed [PROD_W-1:0] K_GU   = 18'sd100;
  localparam logic signed [PROD_W-1:0] K_GV   = 18'sd208;
  localparam logic signed [PROD_W-1:0] K_BU   = 18'sd516;
  localparam logic signed [SUM_W-1:0]  K_RND  = 20'sd128;
  localparam logic signed [9:0]        Y_OFS  = 10'sd16;
  localparam logic signed [9:0]        C_OFS  = 10'sd128;

  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] ye;
    logic [7:0] cr;
    logic [7:0] yo;
    logic       keep_e;
    logic       keep_o;
    logic       fl_e;
    logic       fl_o;
  } grp_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] prv;
    logic signed [PROD_W-1:0] pgu;
    logic signed [PROD_W-1:0] pgv;
    logic signed [PROD_W-1:0] pbu;
    logic                     run_last;
    logic                     frame_last;
  } prod_t;

endpackage

// ===== rtl/uyvy_crop_to_rgb565.sv =====
// ---------------------------------------------------------------------------
// uyvy_crop_to_rgb565
// Crops a UYVY raster stream and converts the kept pixels to RGB565.
// ---------------------------------------------------------------------------
// Input channel: one UYVY group per word (U, Y even, V, Y odd), with
// in_tuser set on the first group of a frame to restart at column 0, row 0.
// Output channel: one RGB565 pixel per word, even pixel first; out_tlast
// marks the last pixel made from a group, out_tuser the last pixel of the
// crop window. Groups outside the window produce no words.
// Configuration: write crop_left, crop_top, out_width, out_height through
// cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Path: an accepted group is written into the queue; each kept pixel then
// passes the product register and the output register. The back end issues
// one pixel per cycle while the output is not stalled, even pixel first.
// A 4-entry group queue decouples input acceptance from pixel output.
// Reset: synchronous, restores the default window (80, 120, 320 x 240),
// clears position, queue and pipeline. When the receiver stalls, the output
// word holds, the pipeline fills, then the queue, then in_tready drops.
// ---------------------------------------------------------------------------
module uyvy_crop_to_rgb565 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ucrop_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ucrop_pkg::REG_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // u_sample, y_even, v_sample, y_odd
  input  logic                              in_tuser,   // frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // pixel
  output logic                              out_tlast,  // run_last
  output logic                              out_tuser   // frame_last
);

  logic            push, pop, q_empty, q_full;
  ucrop_pkg::grp_t push_data, head;

  assign in_tready = !q_full;

  ucrop_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_data (push_data)
  );

  ucrop_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ucrop_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/ucrop_queue.sv =====
// ---------------------------------------------------------------------------
// ucrop_queue
// Short FIFO of classified groups between the front and the back end.
// ---------------------------------------------------------------------------
module ucrop_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ucrop_pkg::grp_t   push_data,
  input  logic              pop,
  output ucrop_pkg::grp_t   head,
  output logic              empty,
  output logic              full
);

  ucrop_pkg::grp_t                    q_mem [ucrop_pkg::QUEUE_DEPTH];
  logic [ucrop_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ucrop_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ucrop_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                               do_push, do_pop;

  assign full    = (count_r == ucrop_pkg::QCNT_W'(ucrop_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ucrop_front.sv =====
// ---------------------------------------------------------------------------
// ucrop_front
// Holds the crop registers, tracks the raster position and marks which
// pixels of each group fall inside the clipped crop window.
// ---------------------------------------------------------------------------
module ucrop_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ucrop_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ucrop_pkg::REG_W-1:0]         cfg_wdata,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [31:0]                         in_tdata,   // u_sample, y_even, v_sample, y_odd
  input  logic                                in_tuser,   // frame_start
  output logic                                push,
  output ucrop_pkg::grp_t                     push_data
);

  localparam int CW = ucrop_pkg::CMP_W;

  logic [ucrop_pkg::REG_W-1:0] crop_left_r, crop_top_r, out_width_r, out_height_r;
  logic [ucrop_pkg::COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ucrop_pkg::ROW_W-1:0] row_r, row_nxt, row_cur;
  logic [CW-1:0]               x_end_raw, y_end_raw, x_end, y_end;
  logic [CW-1:0]               xe, xo, yr, col_step;
  logic                        row_in, keep_e, keep_o, accept;

  assign accept  = in_tvalid && in_tready;
  assign col_cur = in_tuser ? '0 : col_r;
  assign row_cur = in_tuser ? '0 : row_r;

  always_comb begin
    x_end_raw = CW'(crop_left_r) + CW'(out_width_r);
    y_end_raw = CW'(crop_top_r) + CW'(out_height_r);
    x_end = (x_end_raw > CW'(ucrop_pkg::NATIVE_WIDTH)) ?
            CW'(ucrop_pkg::NATIVE_WIDTH) : x_end_raw;
    y_end = (y_end_raw > CW'(ucrop_pkg::NATIVE_HEIGHT)) ?
            CW'(ucrop_pkg::NATIVE_HEIGHT) : y_end_raw;
    xe = CW'(col_cur);
    xo = xe + 1'b1;
    yr = CW'(row_cur);
    row_in = (yr >= CW'(crop_top_r)) && (yr < y_end);
    keep_e = row_in && (xe >= CW'(crop_left_r)) && (xe < x_end);
    keep_o = row_in && (xo >= CW'(crop_left_r)) && (xo < x_end);

    push_data.cb     = in_tdata[7:0];
    push_data.ye     = in_tdata[15:8];
    push_data.cr     = in_tdata[23:16];
    push_data.yo     = in_tdata[31:24];
    push_data.keep_e = keep_e;
    push_data.keep_o = keep_o;
    push_data.fl_e   = (xo == x_end) && (yr + 1'b1 == y_end);
    push_data.fl_o   = (xo + 1'b1 == x_end) && (yr + 1'b1 == y_end);
    push = accept && (keep_e || keep_o);
  end

  // advance two columns per group, wrap into the next row, hold past the last row
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    col_step = xe + CW'(2);
    if (accept) begin
      col_nxt = col_cur;
      row_nxt = row_cur;
      if (yr < CW'(ucrop_pkg::NATIVE_HEIGHT)) begin
        if (col_step >= CW'(ucrop_pkg::NATIVE_WIDTH)) begin
          col_nxt = '0;
          row_nxt = row_cur + 1'b1;
        end else begin
          col_nxt = col_step[ucrop_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_left_r  <= ucrop_pkg::RST_CROP_LEFT;
      crop_top_r   <= ucrop_pkg::RST_CROP_TOP;
      out_width_r  <= ucrop_pkg::RST_OUT_WIDTH;
      out_height_r <= ucrop_pkg::RST_OUT_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        ucrop_pkg::REG_CROP_LEFT:  crop_left_r  <= cfg_wdata;
        ucrop_pkg::REG_CROP_TOP:   crop_top_r   <= cfg_wdata;
        ucrop_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_wdata;
        ucrop_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ucrop_back.sv =====
// ---------------------------------------------------------------------------
// ucrop_back
// Splits each queued group into kept pixels, one per cycle unless stalled,
// feeding a two-stage YCbCr to RGB565 pipeline with an output register.
// ---------------------------------------------------------------------------
module ucrop_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ucrop_pkg::grp_t   head,
  input  logic              empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // pixel
  output logic              out_tlast,   // run_last
  output logic              out_tuser    // frame_last
);

  localparam int PW = ucrop_pkg::PROD_W;
  localparam int SW = ucrop_pkg::SUM_W;

  function automatic logic [7:0] clamp_byte(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] q;
    q = s >>> 8;
    if (q < 0) begin
      clamp_byte = 8'd0;
    end else if (q > SW'(255)) begin
      clamp_byte = 8'd255;
    end else begin
      clamp_byte = q[7:0];
    end
  endfunction

  logic                 phase_r, phase_nxt;
  logic                 sel_odd, last_pix, issue, s1_ready, s2_ready;
  logic [7:0]           y_sel;
  logic signed [9:0]    c_s, d_s, e_s;
  logic                 s1_valid_r;
  ucrop_pkg::prod_t     s1_r, s1_nxt;
  logic signed [SW-1:0] r_sum, g_sum, b_sum;
  logic [7:0]           r8, g8, b8;
  logic                 out_valid_r;
  logic [15:0]          pixel_r;
  logic                 run_last_r, frame_last_r;

  assign s2_ready = !out_valid_r || out_tready;
  assign s1_ready = !s1_valid_r || s2_ready;

  // even pixel first; skip it when it lies outside the window
  always_comb begin
    sel_odd   = !head.keep_e || phase_r;
    last_pix  = sel_odd || !head.keep_o;
    issue     = !empty && s1_ready;
    pop       = issue && last_pix;
    phase_nxt = phase_r;
    if (issue) begin
      phase_nxt = !last_pix;
    end
  end

  always_comb begin
    y_sel = sel_odd ? head.yo : head.ye;
    c_s = $signed({2'b00, y_sel}) - ucrop_pkg::Y_OFS;
    d_s = $signed({2'b00, head.cb}) - ucrop_pkg::C_OFS;
    e_s = $signed({2'b00, head.cr}) - ucrop_pkg::C_OFS;
    s1_nxt.py         = PW'(c_s) * ucrop_pkg::K_Y;
    s1_nxt.prv        = PW'(e_s) * ucrop_pkg::K_RV;
    s1_nxt.pgu        = PW'(d_s) * ucrop_pkg::K_GU;
    s1_nxt.pgv        = PW'(e_s) * ucrop_pkg::K_GV;
    s1_nxt.pbu        = PW'(d_s) * ucrop_pkg::K_BU;
    s1_nxt.run_last   = last_pix;
    s1_nxt.frame_last = sel_odd ? head.fl_o : head.fl_e;
  end

  always_comb begin
    r_sum = SW'(s1_r.py) + SW'(s1_r.prv) + ucrop_pkg::K_RND;
    g_sum = SW'(s1_r.py) - SW'(s1_r.pgu) - SW'(s1_r.pgv) + ucrop_pkg::K_RND;
    b_sum = SW'(s1_r.py) + SW'(s1_r.pbu) + ucrop_pkg::K_RND;
    r8 = clamp_byte(r_sum);
    g8 = clamp_byte(g_sum);
    b8 = clamp_byte(b_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (s1_ready) begin
        s1_valid_r <= issue;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      pixel_r      <= {r8[7:3], g8[7:2], b8[7:3]};
      run_last_r   <= s1_r.run_last;
      frame_last_r <= s1_r.frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pixel_r;
  assign out_tlast  = run_last_r;
  assign out_tuser  = frame_last_r;

endmodule

// ===== rtl/ucrop_checker.sv =====
// ---------------------------------------------------------------------------
// ucrop_checker
// Port-level checks of the UYVY crop block, bound to the top level.
// ---------------------------------------------------------------------------
`include "uyvy_crop_to_rgb565_assert.svh"

module ucrop_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [15:0]                       out_tdata,
  input logic                              out_tlast,
  input logic                              out_tuser
);

  logic        stalled;
  logic [17:0] out_word;

  assign stalled  = out_tvalid && !out_tready;
  assign out_word = {out_tdata, out_tlast, out_tuser};

  `UCROP_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_word), "stalled word changed")
  `UCROP_ASSERT_SAME(a_frame_last_run, out_tvalid && out_tuser, out_tlast, "frame end mid-group")
  `UCROP_ASSERT_SAME(a_reset_out, $past(!rst_n), !out_tvalid, "output valid right after reset")
  `UCROP_ASSERT_SAME(a_reset_in, $past(!rst_n), in_tready, "input not ready right after reset")

endmodule

bind uyvy_crop_to_rgb565 ucrop_checker u_ucrop_checker (.*);

// ===== sim/rgb565_crop_checker.sv =====
// ----------------------------------------------------------------------------
// rgb565_crop_checker
// Watches the configuration port and both stream channels of the UYVY crop
// block, predicts the RGB565 pixels of every accepted group and compares
// each output word field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module rgb565_crop_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ucrop_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ucrop_pkg::REG_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // u_sample, y_even, v_sample, y_odd
  input  logic                             in_tuser,   // frame_start
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [15:0]                      out_tdata,  // pixel
  input  logic                             out_tlast,  // run_last
  input  logic                             out_tuser,  // frame_last
  output int                               pixels_due,
  output int                               mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] pixel;
    logic        run_last;
    logic        frame_last;
  } pixel_word_t;

  pixel_word_t                 pixel_q[$];
  logic [ucrop_pkg::REG_W-1:0] crop_left, crop_top, win_width, win_height;
  int                          col_pos, row_pos;

  initial begin
    mismatches = 0;
    pixels_due = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // floor divide by 256, then saturate to a byte
  function automatic logic [7:0] sat_byte(input int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic logic [15:0] yuv_to_rgb565(input logic [7:0] y, cb, cr);
    int         c, d, e;
    logic [7:0] r, g, b;
    c = int'(y) - 16;
    d = int'(cb) - 128;
    e = int'(cr) - 128;
    r = sat_byte(298 * c + 409 * e + 128);
    g = sat_byte(298 * c - 100 * d - 208 * e + 128);
    b = sat_byte(298 * c + 516 * d + 128);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic void predict_group(input logic [31:0] word, input logic frame_start);
    int          x_end, y_end, x, n;
    bit          row_in;
    pixel_word_t px[2];
    if (frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // clip the window to the native frame
    x_end  = int'(crop_left) + int'(win_width);
    y_end  = int'(crop_top) + int'(win_height);
    x_end  = (x_end < ucrop_pkg::NATIVE_WIDTH) ? x_end : ucrop_pkg::NATIVE_WIDTH;
    y_end  = (y_end < ucrop_pkg::NATIVE_HEIGHT) ? y_end : ucrop_pkg::NATIVE_HEIGHT;
    row_in = row_pos >= int'(crop_top) && row_pos < y_end;
    n = 0;
    for (int k = 0; k < 2; k++) begin
      x = col_pos + k;
      if (row_in && x >= int'(crop_left) && x < x_end) begin
        px[n].pixel      = yuv_to_rgb565(k ? word[31:24] : word[15:8], word[7:0],
                                         word[23:16]);
        px[n].run_last   = 1'b0;
        px[n].frame_last = (x + 1 == x_end) && (row_pos + 1 == y_end);
        n++;
      end
    end
    if (n > 0) px[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) pixel_q.push_back(px[k]);
    // the row saturates past the last native row
    if (row_pos < ucrop_pkg::NATIVE_HEIGHT) begin
      col_pos += 2;
      if (col_pos >= ucrop_pkg::NATIVE_WIDTH) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endfunction

  always @(posedge clk) begin
    pixel_word_t got, want;
    if (!rst_n) begin
      crop_left  = ucrop_pkg::RST_CROP_LEFT;
      crop_top   = ucrop_pkg::RST_CROP_TOP;
      win_width  = ucrop_pkg::RST_OUT_WIDTH;
      win_height = ucrop_pkg::RST_OUT_HEIGHT;
      col_pos    = 0;
      row_pos    = 0;
      pixel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ucrop_pkg::REG_CROP_LEFT:  crop_left  = cfg_wdata;
          ucrop_pkg::REG_CROP_TOP:   crop_top   = cfg_wdata;
          ucrop_pkg::REG_OUT_WIDTH:  win_width  = cfg_wdata;
          ucrop_pkg::REG_OUT_HEIGHT: win_height = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = '{pixel: out_tdata, run_last: out_tlast, frame_last: out_tuser};
        if (pixel_q.size() == 0) begin
          report($sformatf("word %h with no pixel predicted", got.pixel));
        end else begin
          want = pixel_q.pop_front();
          if (got.pixel !== want.pixel)
            report($sformatf("pixel %h, predicted %h", got.pixel, want.pixel));
          if (got.run_last !== want.run_last)
            report($sformatf("run_last %b, predicted %b", got.run_last, want.run_last));
          if (got.frame_last !== want.frame_last)
            report($sformatf("frame_last %b, predicted %b", got.frame_last,
                             want.frame_last));
        end
      end
      if (in_tvalid && in_tready) predict_group(in_tdata, in_tuser);
    end
    pixels_due <= pixel_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the UYVY crop and RGB565 block: directed color and window-edge
// groups, empty and clipped windows, one long output hold-off at full input
// rate, then random windows with random group data and random idling on both
// channels. Prediction and comparison live in rgb565_crop_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_GROUPS  = 775;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_we     = 1'b0;
  logic [ucrop_pkg::CFG_ADDR_W-1:0] cfg_addr   = ucrop_pkg::REG_CROP_LEFT;
  logic [ucrop_pkg::REG_W-1:0]      cfg_wdata  = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [31:0]                      in_tdata   = '0;
  logic                             in_tuser   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [15:0]                      out_tdata;
  logic                             out_tlast;
  logic                             out_tuser;

  int pixels_due;
  int mismatches;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit rx_hold = 1'b0;
  bit hung    = 1'b0;

  uyvy_crop_to_rgb565 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  rgb565_crop_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .pixels_due (pixels_due),
    .mismatches (mismatches)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // pixel receiver: random stalls per word, plus one long hold-off on request
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      stall = rx_gaps ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_group(input logic [7:0] u, ye, v, yo, input logic fs);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yo, v, ye, u};
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering, drain predicted pixels, then let empty groups flush
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pixels_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ucrop_pkg::CFG_ADDR_W-1:0] addr, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= ucrop_pkg::REG_W'(value);
    @(negedge clk);
  endtask

  task automatic set_window(input int left, top, width, height);
    settle();
    write_reg(ucrop_pkg::REG_CROP_LEFT, left);
    write_reg(ucrop_pkg::REG_CROP_TOP, top);
    write_reg(ucrop_pkg::REG_OUT_WIDTH, width);
    write_reg(ucrop_pkg::REG_OUT_HEIGHT, height);
    cfg_we <= 1'b0;
  endtask

  // random groups in frames of frame_len groups; noisy adds stray frame starts
  task automatic run_frames(input int groups, frame_len, input bit noisy,
                            input int hold_at);
    int pos;
    bit fs;
    pos = 0;
    for (int i = 0; i < groups; i++) begin
      fs = (i == 0) || (pos == frame_len) || (noisy && $urandom_range(0, 63) == 0);
      if (fs) pos = 0;
      pos++;
      if (i == hold_at) begin
        tx_gaps = 1'b0;
        rx_hold = 1'b1;
      end
      send_group(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), fs);
    end
  endtask

  initial begin
    int sent, left, top, width, height, groups;
    fork
      begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // color extremes over a full-frame window
        set_window(0, 0, ucrop_pkg::NATIVE_WIDTH, ucrop_pkg::NATIVE_HEIGHT);
        send_group(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        send_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_group(8'd128, 8'd16,  8'd128, 8'd235, 1'b0);
        send_group(8'd0,   8'd255, 8'd255, 8'd0,   1'b0);
        send_group(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
        send_group(8'd128, 8'd255, 8'd255, 8'd255, 1'b0);
        send_group(8'd90,  8'd81,  8'd240, 8'd81,  1'b0);
        send_group(8'd54,  8'd145, 8'd34,  8'd145, 1'b0);
        send_group(8'd240, 8'd41,  8'd110, 8'd41,  1'b0);
        send_group(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
        send_group(8'd0,   8'd16,  8'd0,   8'd16,  1'b0);
        send_group(8'd255, 8'd235, 8'd255, 8'd235, 1'b0);
        send_group(8'hAA,  8'h55,  8'h55,  8'hAA,  1'b0);
        send_group(8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0);

        // odd window edges: odd pixel only, pair, even pixel only with frame end
        set_window(3, 0, 4, 1);
        send_group(8'd20,  8'd60,  8'd200, 8'd90,  1'b1);
        send_group(8'd100, 8'd120, 8'd140, 8'd160, 1'b0);
        send_group(8'd30,  8'd230, 8'd60,  8'd20,  1'b0);
        send_group(8'd180, 8'd70,  8'd40,  8'd210, 1'b0);
        send_group(8'd1,   8'd2,   8'd3,   8'd4,   1'b0);

        // window clipped to the last native column, then restart
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        set_window(ucrop_pkg::NATIVE_WIDTH - 1, 0, ucrop_pkg::NATIVE_WIDTH, 1);
        run_frames(ucrop_pkg::NATIVE_WIDTH / 2 + 3, ucrop_pkg::NATIVE_WIDTH / 2 + 3,
                   1'b0, -1);
        run_frames(3, 3, 1'b0, -1);

        // empty windows: outside, zero width, zero height, all ones
        set_window(500, 0, 10, 2);
        run_frames(20, 20, 1'b0, -1);
        set_window(0, 0, 0, 1);
        run_frames(20, 20, 1'b0, -1);
        set_window(0, 0, 8, 0);
        run_frames(20, 20, 1'b0, -1);
        set_window(511, 511, 511, 511);
        run_frames(10, 10, 1'b0, -1);

        // hold the receiver off while groups keep coming at full rate
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        set_window(0, 0, ucrop_pkg::NATIVE_WIDTH, ucrop_pkg::NATIVE_HEIGHT);
        run_frames(40, 40, 1'b0, 0);

        // random windows near the top rows so most groups land inside
        sent = 0;
        while (sent < RANDOM_GROUPS) begin
          top    = ($urandom_range(0, 3) == 0) ? 1 : 0;
          height = ($urandom_range(0, 3) == 0) ? 2 : 1;
          left   = $urandom_range(0, 240);
          width  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16)
                                                : $urandom_range(160, ucrop_pkg::NATIVE_WIDTH);
          groups = $urandom_range(200, 450);
          if (groups > RANDOM_GROUPS - sent) groups = RANDOM_GROUPS - sent;
          set_window(left, top, width, height);
          tx_gaps = $urandom_range(0, 3) != 0;
          rx_gaps = $urandom_range(0, 3) != 0;
          run_frames(groups,
                     (top + height) * (ucrop_pkg::NATIVE_WIDTH / 2) + $urandom_range(0, 4),
                     1'b1, -1);
          sent += groups;
        end
        settle();
      end
      begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
          @(posedge clk);
          if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
          else idle++;
        end
        hung = 1'b1;
      end
    join_any
    if (!hung && mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
